// ===== hdl/day_number_date_converter_defines.svh =====
// Assertion macros shared by the day number converter RTL
`ifndef DAY_NUMBER_DATE_CONVERTER_DEFINES_SVH
`define DAY_NUMBER_DATE_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define DNDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DNDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dndc_pkg.sv =====
// Package: types, constants and tables of the day number converter
package dndc_pkg;

    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int ALU_W   = COUNT_W + 1;

    localparam int MAX_YEAR = 9999;
    // days in all years up to and including MAX_YEAR
    localparam int MAX_COUNT_I = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                                 + MAX_YEAR / 400;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_COUNT_I);
    localparam logic [YEAR_W-1:0]  MAX_YEAR_V = YEAR_W'(MAX_YEAR);

    typedef enum logic [1:0] {
        OP_TO_DATE  = 2'd0,
        OP_TO_COUNT = 2'd1,
        OP_NEXT_DAY = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_LOOP,
        S_SUM,
        S_MONTH,
        S_DONE
    } state_t;

    // cycle levels of the year search
    typedef enum logic [1:0] {
        LVL_400 = 2'd0,
        LVL_100 = 2'd1,
        LVL_4   = 2'd2,
        LVL_1   = 2'd3
    } level_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             borrow;
    } alu_rsp_t;

    function automatic logic [COUNT_W-1:0] step_days(level_t lvl);
        logic [COUNT_W-1:0] d;
        unique case (lvl)
            LVL_400: d = COUNT_W'(146097);
            LVL_100: d = COUNT_W'(36524);
            LVL_4:   d = COUNT_W'(1461);
            LVL_1:   d = COUNT_W'(365);
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [COUNT_W-1:0] step_years(level_t lvl);
        logic [COUNT_W-1:0] y;
        unique case (lvl)
            LVL_400: y = COUNT_W'(400);
            LVL_100: y = COUNT_W'(100);
            LVL_4:   y = COUNT_W'(4);
            LVL_1:   y = COUNT_W'(1);
            default: y = '0;
        endcase
        return y;
    endfunction

    function automatic logic [4:0] month_len(logic [3:0] mo, logic leap);
        logic [4:0] len;
        case (mo) inside
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the months before month m; months past 12 count the whole year
    function automatic logic [8:0] month_offset(logic [3:0] m);
        logic [8:0] off;
        case (m)
            4'd0, 4'd1: off = 9'd0;
            4'd2:       off = 9'd31;
            4'd3:       off = 9'd59;
            4'd4:       off = 9'd90;
            4'd5:       off = 9'd120;
            4'd6:       off = 9'd151;
            4'd7:       off = 9'd181;
            4'd8:       off = 9'd212;
            4'd9:       off = 9'd243;
            4'd10:      off = 9'd273;
            4'd11:      off = 9'd304;
            4'd12:      off = 9'd334;
            default:    off = 9'd365;
        endcase
        return off;
    endfunction

endpackage

// ===== hdl/dndc_addsub.sv =====
// Shared add/subtract unit with borrow out
module dndc_addsub
    import dndc_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] full;

    always_comb
    begin
        full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
               + {{ALU_W{1'b0}}, req.sub};
        rsp.sum    = full[ALU_W-1:0];
        // carry out of a subtract means no borrow
        rsp.borrow = req.sub & ~full[ALU_W];
    end

endmodule

// ===== hdl/day_number_date_converter.sv =====
// Top level: day count / Gregorian date converter with an iterative sequencer
//
//  Channel   Signals                                              Handshake
//  request   opcode day_number year_in month_in day_in            start & !busy
//  result    year_out month_out day_out count_out out_of_range    done (1 cycle)
//
// One item at a time; busy stays high from acceptance through the done cycle.
// The year search subtracts 400/100/4/1-year cycles through one shared
// add/subtract unit, one step a cycle; a day count to date then walks months
// one per cycle. The result is shown for one cycle and cannot be stalled.
// Asynchronous active-low reset returns the sequencer to idle.
`include "day_number_date_converter_defines.svh"

module day_number_date_converter
    import dndc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [COUNT_W-1:0]  day_number,
    input  logic [YEAR_W-1:0]   year_in,
    input  logic [3:0]          month_in,
    input  logic [4:0]          day_in,
    output logic                done,
    output logic [YEAR_W-1:0]   year_out,
    output logic [3:0]          month_out,
    output logic [4:0]          day_out,
    output logic [COUNT_W-1:0]  count_out,
    output logic                out_of_range
);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [COUNT_W-1:0]  dn_reg, dn_next;
    logic [YEAR_W-1:0]   yin_reg, yin_next;
    logic [3:0]          min_reg, min_next;
    logic [4:0]          din_reg, din_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W-1:0]  acc_reg, acc_next;
    level_t              level_reg, level_next;
    logic [4:0]          q_reg, q_next;
    logic [3:0]          mo_reg, mo_next;
    logic                c2d_reg, c2d_next;
    logic                q100_full_reg, q100_full_next;
    logic                q4_full_reg, q4_full_next;
    logic                leap_reg, leap_next;
    logic [YEAR_W-1:0]   yres_reg, yres_next;
    logic [3:0]          mres_reg, mres_next;
    logic [4:0]          dres_reg, dres_next;
    logic [COUNT_W-1:0]  cres_reg, cres_next;
    logic                oor_reg, oor_next;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic                accept;
    logic                take;
    logic [COUNT_W-1:0]  k_sub;
    logic [COUNT_W-1:0]  k_add;
    logic [9:0]          tail;

    dndc_addsub u_addsub (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign accept       = start & (state_reg == S_IDLE);
    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign year_out     = yres_reg;
    assign month_out    = mres_reg;
    assign day_out      = dres_reg;
    assign count_out    = cres_reg;
    assign out_of_range = oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        dn_reg        <= dn_next;
        yin_reg       <= yin_next;
        min_reg       <= min_next;
        din_reg       <= din_next;
        rem_reg       <= rem_next;
        acc_reg       <= acc_next;
        level_reg     <= level_next;
        q_reg         <= q_next;
        mo_reg        <= mo_next;
        c2d_reg       <= c2d_next;
        q100_full_reg <= q100_full_next;
        q4_full_reg   <= q4_full_next;
        leap_reg      <= leap_next;
        yres_reg      <= yres_next;
        mres_reg      <= mres_next;
        dres_reg      <= dres_next;
        cres_reg      <= cres_next;
        oor_reg       <= oor_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        dn_next        = dn_reg;
        yin_next       = yin_reg;
        min_next       = min_reg;
        din_next       = din_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        level_next     = level_reg;
        q_next         = q_reg;
        mo_next        = mo_reg;
        c2d_next       = c2d_reg;
        q100_full_next = q100_full_reg;
        q4_full_next   = q4_full_reg;
        leap_next      = leap_reg;
        yres_next      = yres_reg;
        mres_next      = mres_reg;
        dres_next      = dres_reg;
        cres_next      = cres_reg;
        oor_next       = oor_reg;

        // year search steps: subtract one table, accumulate the other
        k_sub = c2d_reg ? step_days(level_reg) : step_years(level_reg);
        k_add = c2d_reg ? step_years(level_reg) : step_days(level_reg);
        tail  = {1'b0, month_offset(min_reg)}
                + {9'd0, ((min_reg > 4'd2) && leap_reg)}
                + {5'd0, din_reg};

        alu_req.a   = {1'b0, rem_reg};
        alu_req.b   = {1'b0, k_sub};
        alu_req.sub = 1'b1;
        take        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op_t'(opcode);
                    dn_next   = day_number;
                    yin_next  = year_in;
                    min_next  = month_in;
                    din_next  = day_in;
                    yres_next = '0;
                    mres_next = '0;
                    dres_next = '0;
                    cres_next = '0;
                    oor_next  = 1'b0;
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                unique case (op_reg)
                    OP_TO_DATE:
                    begin
                        alu_req.a = {1'b0, dn_reg};
                        alu_req.b = ALU_W'(1);
                        if (dn_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rem_next   = alu_rsp.sum[COUNT_W-1:0];
                            state_next = S_CHECK;
                        end
                    end
                    OP_TO_COUNT, OP_NEXT_DAY:
                    begin
                        alu_req.a  = {{(ALU_W-YEAR_W){1'b0}}, yin_reg};
                        alu_req.b  = ALU_W'(1);
                        acc_next   = '0;
                        level_next = LVL_400;
                        q_next     = '0;
                        c2d_next   = 1'b0;
                        if (yin_reg > MAX_YEAR_V)
                        begin
                            oor_next   = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (yin_reg == '0)
                        begin
                            // year zero: no prior years, counts as leap
                            leap_next  = 1'b1;
                            state_next = S_SUM;
                        end
                        else
                        begin
                            rem_next   = alu_rsp.sum[COUNT_W-1:0];
                            state_next = S_LOOP;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_CHECK:
            begin
                // rem holds count - 1; past the last day of MAX_YEAR is flagged
                alu_req.b  = {1'b0, MAX_COUNT};
                acc_next   = COUNT_W'(1);
                level_next = LVL_400;
                q_next     = '0;
                c2d_next   = 1'b1;
                if (!alu_rsp.borrow)
                begin
                    oor_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LOOP;
                end
            end

            S_LOOP:
            begin
                take = !alu_rsp.borrow &&
                       !(((level_reg == LVL_100) || (level_reg == LVL_1)) &&
                         (q_reg == 5'd3));
                if (take)
                begin
                    rem_next = alu_rsp.sum[COUNT_W-1:0];
                    acc_next = acc_reg + k_add;
                    q_next   = q_reg + 5'd1;
                end
                else
                begin
                    q_next = '0;
                    unique case (level_reg)
                        LVL_400:
                        begin
                            level_next = LVL_100;
                        end
                        LVL_100:
                        begin
                            q100_full_next = (q_reg == 5'd3);
                            level_next     = LVL_4;
                        end
                        LVL_4:
                        begin
                            q4_full_next = (q_reg == 5'd24);
                            level_next   = LVL_1;
                        end
                        default:
                        begin
                            leap_next = (q_reg == 5'd3) && (!q4_full_reg || q100_full_reg);
                            mo_next   = 4'd1;
                            state_next = c2d_reg ? S_MONTH : S_SUM;
                        end
                    endcase
                end
            end

            S_SUM:
            begin
                alu_req.a   = {1'b0, acc_reg};
                alu_req.b   = {{(ALU_W-10){1'b0}}, tail};
                alu_req.sub = 1'b0;
                if (op_reg == OP_TO_COUNT)
                begin
                    cres_next  = alu_rsp.sum[COUNT_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    // next day: the date's count equals the follower's count - 1
                    rem_next   = alu_rsp.sum[COUNT_W-1:0];
                    state_next = S_CHECK;
                end
            end

            S_MONTH:
            begin
                alu_req.b = {{(ALU_W-5){1'b0}}, month_len(mo_reg, leap_reg)};
                if ((mo_reg == 4'd12) || alu_rsp.borrow)
                begin
                    yres_next  = acc_reg[YEAR_W-1:0];
                    mres_next  = mo_reg;
                    dres_next  = rem_reg[4:0] + 5'd1;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next = alu_rsp.sum[COUNT_W-1:0];
                    mo_next  = mo_reg + 4'd1;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `DNDC_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted item did not raise busy")
    `DNDC_ASSERT_NEXT(a_done_release, done, !busy && !done, "done not followed by idle")
    `DNDC_ASSERT_NOW(a_oor_no_date, done && out_of_range,
        year_out == '0 && month_out == '0 && day_out == '0 && count_out == '0,
        "out of range result carries data")
    `DNDC_ASSERT_NOW(a_date_sane, done && month_out != '0,
        day_out != '0 && month_out <= 4'd12 && year_out != '0 && year_out <= MAX_YEAR_V,
        "produced date is malformed")
    `DNDC_ASSERT_NOW(a_count_only, done && count_out != '0,
        month_out == '0 && !out_of_range,
        "day count result mixed with date fields")

endmodule
